@@ rtl/core/ptm_pkg.sv @@
// Shared types, constants and fixed-point helpers for the pose to transform block.
package ptm_pkg;

    // Number of CORDIC micro-rotations, one per cell.
    localparam int CORDIC_STEPS = 30;
    // Start value of x, the inverse CORDIC gain in Q30.
    localparam logic signed [33:0] CORDIC_X0 = 34'sd652032874;
    localparam logic signed [67:0] HALF_Q30 = 68'sd536870912;
    localparam logic signed [37:0] SAT_MAX = 38'sd2147483647;
    localparam logic signed [37:0] SAT_MIN = -38'sd2147483648;

    // One input item.
    typedef struct packed {
        logic [15:0]        roll_angle;
        logic [15:0]        pitch_angle;
        logic [15:0]        yaw_angle;
        logic signed [31:0] shift_x;
        logic signed [31:0] shift_y;
        logic signed [31:0] shift_z;
        logic signed [31:0] gain_x;
        logic signed [31:0] gain_y;
        logic signed [31:0] gain_z;
    } t_pose_item;

    // One result item.
    typedef struct packed {
        logic signed [31:0] m_row0_col0;
        logic signed [31:0] m_row0_col1;
        logic signed [31:0] m_row0_col2;
        logic signed [31:0] m_row0_col3;
        logic signed [31:0] m_row1_col0;
        logic signed [31:0] m_row1_col1;
        logic signed [31:0] m_row1_col2;
        logic signed [31:0] m_row1_col3;
        logic signed [31:0] m_row2_col0;
        logic signed [31:0] m_row2_col1;
        logic signed [31:0] m_row2_col2;
        logic signed [31:0] m_row2_col3;
    } t_mat_item;

    // CORDIC state of one angle.
    typedef struct packed {
        logic signed [33:0] x;
        logic signed [33:0] y;
        logic signed [32:0] z;
        logic [1:0]         quad;
    } t_rot;

    // What one CORDIC cell holds: three angles and the untouched payload.
    typedef struct packed {
        t_rot [2:0]                rot;
        logic [2:0][31:0]          shift;
        logic [2:0][31:0]          gain;
    } t_cord;

    // Arctangent of 2^-step as a fraction of a 2^32 turn.
    function automatic logic signed [32:0] atan_turn(input int step);
        logic signed [32:0] v;
        case (step)
            0:  v = 33'sd536870912;
            1:  v = 33'sd316933406;
            2:  v = 33'sd167458907;
            3:  v = 33'sd85004756;
            4:  v = 33'sd42667331;
            5:  v = 33'sd21354465;
            6:  v = 33'sd10679838;
            7:  v = 33'sd5340245;
            8:  v = 33'sd2670163;
            9:  v = 33'sd1335087;
            10: v = 33'sd667544;
            11: v = 33'sd333772;
            12: v = 33'sd166886;
            13: v = 33'sd83443;
            14: v = 33'sd41722;
            15: v = 33'sd20861;
            16: v = 33'sd10430;
            17: v = 33'sd5215;
            18: v = 33'sd2608;
            19: v = 33'sd1304;
            20: v = 33'sd652;
            21: v = 33'sd326;
            22: v = 33'sd163;
            23: v = 33'sd81;
            24: v = 33'sd41;
            25: v = 33'sd20;
            26: v = 33'sd10;
            27: v = 33'sd5;
            28: v = 33'sd3;
            29: v = 33'sd1;
            default: v = 33'sd0;
        endcase
        return v;
    endfunction

    // Q30 product, rounded to nearest with ties towards plus infinity.
    function automatic logic signed [37:0] mulq30(input logic signed [33:0] a,
                                                  input logic signed [33:0] b);
        logic signed [67:0] p;
        p = a * b;
        p = p + HALF_Q30;
        return p[67:30];
    endfunction

    // Clamp to the signed 32-bit range.
    function automatic logic signed [31:0] sat32(input logic signed [37:0] v);
        logic signed [37:0] c;
        c = v;
        if (v > SAT_MAX) begin
            c = SAT_MAX;
        end else if (v < SAT_MIN) begin
            c = SAT_MIN;
        end
        return c[31:0];
    endfunction

endpackage

@@ rtl/core/ptm_stream_if.sv @@
// Valid/ready stream channel carrying one item of type T.
interface ptm_stream_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ rtl/core/ptm_cordic_cell.sv @@
// One CORDIC micro-rotation cell, working on all three angles of an item.
module ptm_cordic_cell #(
    parameter int STEP = 0
) (
    input  logic           i_clk,
    input  logic           i_en,
    input  ptm_pkg::t_cord i_data,
    output ptm_pkg::t_cord o_data
);
    import ptm_pkg::*;

    t_cord n_data;
    t_cord r_data;

    // Rotate towards zero residual angle; the sign of z picks the direction.
    always_comb begin
        n_data = i_data;
        for (int k = 0; k < 3; k++) begin
            if (!i_data.rot[k].z[32]) begin
                n_data.rot[k].x = i_data.rot[k].x - (i_data.rot[k].y >>> STEP);
                n_data.rot[k].y = i_data.rot[k].y + (i_data.rot[k].x >>> STEP);
                n_data.rot[k].z = i_data.rot[k].z - atan_turn(STEP);
            end else begin
                n_data.rot[k].x = i_data.rot[k].x + (i_data.rot[k].y >>> STEP);
                n_data.rot[k].y = i_data.rot[k].y - (i_data.rot[k].x >>> STEP);
                n_data.rot[k].z = i_data.rot[k].z + atan_turn(STEP);
            end
        end
    end

    // Hand the result to the next cell.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_data = r_data;
endmodule

@@ rtl/core/ptm_rot_mul.sv @@
// Quadrant fix-up, rotation matrix products and scaling, three registered stages.
module ptm_rot_mul (
    input  logic               i_clk,
    input  logic               i_en,
    input  ptm_pkg::t_cord     i_data,
    output ptm_pkg::t_mat_item o_data
);
    import ptm_pkg::*;

    typedef struct packed {
        logic signed [33:0] cysp;
        logic signed [33:0] sysp;
        logic signed [33:0] r00;
        logic signed [33:0] sycr;
        logic signed [33:0] sysr;
        logic signed [33:0] r10;
        logic signed [33:0] cycr;
        logic signed [33:0] cysr;
        logic signed [33:0] r20;
        logic signed [33:0] r21;
        logic signed [33:0] r22;
        logic signed [33:0] sr;
        logic signed [33:0] cr;
        logic [2:0][31:0]   shift;
        logic [2:0][31:0]   gain;
    } t_prod1;

    typedef struct packed {
        logic [8:0][33:0] r;
        logic [2:0][31:0] shift;
        logic [2:0][31:0] gain;
    } t_prod2;

    logic signed [33:0] w_cos [3];
    logic signed [33:0] w_sin [3];
    t_prod1    n_p1, r_p1;
    t_prod2    n_p2, r_p2;
    t_mat_item n_out, r_out;

    // Turn each CORDIC result by its quadrant.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            case (i_data.rot[k].quad)
                2'd1: begin
                    w_cos[k] = -i_data.rot[k].y;
                    w_sin[k] = i_data.rot[k].x;
                end
                2'd2: begin
                    w_cos[k] = -i_data.rot[k].x;
                    w_sin[k] = -i_data.rot[k].y;
                end
                2'd3: begin
                    w_cos[k] = i_data.rot[k].y;
                    w_sin[k] = -i_data.rot[k].x;
                end
                default: begin
                    w_cos[k] = i_data.rot[k].x;
                    w_sin[k] = i_data.rot[k].y;
                end
            endcase
        end
    end

    // First products: index 0 is roll, 1 is pitch, 2 is yaw.
    always_comb begin
        n_p1.cysp  = 34'(mulq30(w_cos[2], w_sin[1]));
        n_p1.sysp  = 34'(mulq30(w_sin[2], w_sin[1]));
        n_p1.r00   = 34'(mulq30(w_cos[2], w_cos[1]));
        n_p1.sycr  = 34'(mulq30(w_sin[2], w_cos[0]));
        n_p1.sysr  = 34'(mulq30(w_sin[2], w_sin[0]));
        n_p1.r10   = 34'(mulq30(w_sin[2], w_cos[1]));
        n_p1.cycr  = 34'(mulq30(w_cos[2], w_cos[0]));
        n_p1.cysr  = 34'(mulq30(w_cos[2], w_sin[0]));
        n_p1.r20   = -w_sin[1];
        n_p1.r21   = 34'(mulq30(w_cos[1], w_sin[0]));
        n_p1.r22   = 34'(mulq30(w_cos[1], w_cos[0]));
        n_p1.sr    = w_sin[0];
        n_p1.cr    = w_cos[0];
        n_p1.shift = i_data.shift;
        n_p1.gain  = i_data.gain;
    end

    // Second products with the roll terms, then the sums of the mixed entries.
    always_comb begin
        n_p2.r[0] = r_p1.r00;
        n_p2.r[1] = 34'(mulq30(r_p1.cysp, r_p1.sr)) - r_p1.sycr;
        n_p2.r[2] = 34'(mulq30(r_p1.cysp, r_p1.cr)) + r_p1.sysr;
        n_p2.r[3] = r_p1.r10;
        n_p2.r[4] = 34'(mulq30(r_p1.sysp, r_p1.sr)) + r_p1.cycr;
        n_p2.r[5] = 34'(mulq30(r_p1.sysp, r_p1.cr)) - r_p1.cysr;
        n_p2.r[6] = r_p1.r20;
        n_p2.r[7] = r_p1.r21;
        n_p2.r[8] = r_p1.r22;
        n_p2.shift = r_p1.shift;
        n_p2.gain  = r_p1.gain;
    end

    // Scale each column by its gain, round and clamp.
    always_comb begin
        n_out.m_row0_col0 = sat32(mulq30($signed(r_p2.r[0]), 34'($signed(r_p2.gain[2]))));
        n_out.m_row0_col1 = sat32(mulq30($signed(r_p2.r[1]), 34'($signed(r_p2.gain[1]))));
        n_out.m_row0_col2 = sat32(mulq30($signed(r_p2.r[2]), 34'($signed(r_p2.gain[0]))));
        n_out.m_row0_col3 = r_p2.shift[2];
        n_out.m_row1_col0 = sat32(mulq30($signed(r_p2.r[3]), 34'($signed(r_p2.gain[2]))));
        n_out.m_row1_col1 = sat32(mulq30($signed(r_p2.r[4]), 34'($signed(r_p2.gain[1]))));
        n_out.m_row1_col2 = sat32(mulq30($signed(r_p2.r[5]), 34'($signed(r_p2.gain[0]))));
        n_out.m_row1_col3 = r_p2.shift[1];
        n_out.m_row2_col0 = sat32(mulq30($signed(r_p2.r[6]), 34'($signed(r_p2.gain[2]))));
        n_out.m_row2_col1 = sat32(mulq30($signed(r_p2.r[7]), 34'($signed(r_p2.gain[1]))));
        n_out.m_row2_col2 = sat32(mulq30($signed(r_p2.r[8]), 34'($signed(r_p2.gain[0]))));
        n_out.m_row2_col3 = r_p2.shift[0];
    end

    // Stage registers; the last one is the output register.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p1  <= n_p1;
            r_p2  <= n_p2;
            r_out <= n_out;
        end
    end

    assign o_data = r_out;
endmodule

@@ rtl/core/pose_to_scaled_transform_matrix.sv @@
// Top level: pose to scaled homogeneous transform, streaming pipeline.
// Each pose item passes through a chain of 30 CORDIC cells, one micro-rotation
// per cell for roll, pitch and yaw at once, and then three multiply stages that
// build the rotation matrix and scale its columns. An accepted item passes
// through 33 registers, the accepting edge loading the first, and one item
// is accepted in every cycle in which the output register is empty or being
// read. When a result is held at the output the whole pipeline stands still
// and input ready drops. Angles use the low ANGLE_BITS bits of each angle
// field, with 2^ANGLE_BITS being one turn.
module pose_to_scaled_transform_matrix #(
    parameter int ANGLE_BITS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ptm_stream_if.sink    i_pose,
    ptm_stream_if.source  o_mat
);
    import ptm_pkg::*;

    localparam int NSTG = CORDIC_STEPS + 3;

    logic            w_en;
    logic            w_acc;
    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] n_vld;
    t_cord           w_cord [CORDIC_STEPS+1];
    logic [31:0]     w_turn [3];
    t_mat_item       w_out;

    // The pipeline moves whenever the output register can take a new item.
    assign w_en  = !r_vld[NSTG-1] || o_mat.ready;
    assign w_acc = i_pose.valid && w_en;
    assign i_pose.ready = w_en;

    // Widen each angle to a 2^32 turn and seed the CORDIC.
    always_comb begin
        w_turn[0] = (32'(i_pose.data.roll_angle) & ((32'd1 << ANGLE_BITS) - 32'd1))
                    << (32 - ANGLE_BITS);
        w_turn[1] = (32'(i_pose.data.pitch_angle) & ((32'd1 << ANGLE_BITS) - 32'd1))
                    << (32 - ANGLE_BITS);
        w_turn[2] = (32'(i_pose.data.yaw_angle) & ((32'd1 << ANGLE_BITS) - 32'd1))
                    << (32 - ANGLE_BITS);
        for (int k = 0; k < 3; k++) begin
            w_cord[0].rot[k].x    = CORDIC_X0;
            w_cord[0].rot[k].y    = '0;
            w_cord[0].rot[k].z    = {3'b000, w_turn[k][29:0]};
            w_cord[0].rot[k].quad = w_turn[k][31:30];
        end
        w_cord[0].shift[2] = i_pose.data.shift_x;
        w_cord[0].shift[1] = i_pose.data.shift_y;
        w_cord[0].shift[0] = i_pose.data.shift_z;
        w_cord[0].gain[2]  = i_pose.data.gain_x;
        w_cord[0].gain[1]  = i_pose.data.gain_y;
        w_cord[0].gain[0]  = i_pose.data.gain_z;
    end

    // Chain of CORDIC cells.
    for (genvar s = 0; s < CORDIC_STEPS; s++) begin : g_cell
        ptm_cordic_cell #(.STEP(s)) u_cell (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_data (w_cord[s]),
            .o_data (w_cord[s+1])
        );
    end

    // Matrix products and scaling.
    ptm_rot_mul u_rot_mul (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_data (w_cord[CORDIC_STEPS]),
        .o_data (w_out)
    );

    // Valid bits travel alongside the item through every stage.
    always_comb begin
        n_vld = r_vld;
        if (w_en) begin
            n_vld = {r_vld[NSTG-2:0], w_acc};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_mat.valid = r_vld[NSTG-1];
    assign o_mat.data  = w_out;

`ifndef SYNTH
    a_hold_when_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_vld))
        else $error("valid bits moved while the pipeline was stalled");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pose.valid && i_pose.ready) |=> r_vld[0])
        else $error("accepted item did not enter the first cell");

    a_shift_on_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_en |=> (r_vld[NSTG-1:1] == $past(r_vld[NSTG-2:0])))
        else $error("valid bits lost or invented while the pipeline moved");
`endif
endmodule

@@ tb/tb_top.sv @@
// Testbench for the pose to scaled transform block, checked against a local predictor.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import ptm_pkg::*;

    logic i_clk;
    logic i_rst_n;
    bit   failed;
    bit   hold_long;

    ptm_stream_if #(.T(t_pose_item)) pose_ch ();
    ptm_stream_if #(.T(t_mat_item))  mat_ch ();

    pose_to_scaled_transform_matrix i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pose  (pose_ch.sink),
        .o_mat   (mat_ch.source)
    );

    // Clock generation.
    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    t_mat_item matrix_queue[$];

    // Append one expected matrix to the queue.
    function automatic void queue_matrix(input t_mat_item m);
        matrix_queue = {matrix_queue, m};
    endfunction

    // Arithmetic shift right of a 64-bit value.
    function automatic longint shr_arith(longint v, int n);
        return v >>> n;
    endfunction

    // Rounded Q30 product.
    function automatic longint round_q30(longint a, longint b);
        return (a * b + 64'sd536870912) >>> 30;
    endfunction

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) begin
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            return -64'sd2147483648;
        end
        return v;
    endfunction

    // Cosine and sine in Q30 of a binary angle, by CORDIC then quadrant turn.
    task automatic angle_sincos(input logic [15:0] ang, output longint c, output longint s);
        longint atans[30];
        logic [31:0] a32;
        longint x, y, z, nx;
        atans = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
                  10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
                  41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
                  10, 5, 3, 1};
        a32 = {ang, 16'h0000};
        z = longint'(a32[29:0]);
        x = 652032874;
        y = 0;
        for (int i = 0; i < 30; i++) begin
            if (z >= 0) begin
                nx = x - shr_arith(y, i);
                y = y + shr_arith(x, i);
                z = z - atans[i];
            end else begin
                nx = x + shr_arith(y, i);
                y = y - shr_arith(x, i);
                z = z + atans[i];
            end
            x = nx;
        end
        case (a32[31:30])
            2'd1: begin c = -y; s = x; end
            2'd2: begin c = -x; s = -y; end
            2'd3: begin c = y; s = -x; end
            default: begin c = x; s = y; end
        endcase
    endtask

    // Expected transform matrix of one pose.
    task automatic build_transform(input t_pose_item p, output t_mat_item m);
        longint cr, sr, cp, sp, cy, sy, cysp, sysp;
        longint rot[3][3];
        longint g[3];
        logic [31:0] e[12];
        angle_sincos(p.roll_angle, cr, sr);
        angle_sincos(p.pitch_angle, cp, sp);
        angle_sincos(p.yaw_angle, cy, sy);
        g[0] = p.gain_x;
        g[1] = p.gain_y;
        g[2] = p.gain_z;
        cysp = round_q30(cy, sp);
        sysp = round_q30(sy, sp);
        rot[0][0] = round_q30(cy, cp);
        rot[0][1] = round_q30(cysp, sr) - round_q30(sy, cr);
        rot[0][2] = round_q30(cysp, cr) + round_q30(sy, sr);
        rot[1][0] = round_q30(sy, cp);
        rot[1][1] = round_q30(sysp, sr) + round_q30(cy, cr);
        rot[1][2] = round_q30(sysp, cr) - round_q30(cy, sr);
        rot[2][0] = -sp;
        rot[2][1] = round_q30(cp, sr);
        rot[2][2] = round_q30(cp, cr);
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                e[r * 4 + c] = 32'(clamp32(round_q30(rot[r][c], g[c])));
            end
        end
        e[3] = p.shift_x;
        e[7] = p.shift_y;
        e[11] = p.shift_z;
        m = {e[0], e[1], e[2], e[3], e[4], e[5], e[6], e[7], e[8], e[9], e[10], e[11]};
    endtask

    // Send one pose after a random gap and record its expected matrix.
    task automatic send_pose(input t_pose_item p);
        t_mat_item m;
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
        // Valid stays high from the previous item unless there is a gap.
        if (gap != 0) begin
            pose_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        pose_ch.data <= p;
        pose_ch.valid <= 1'b1;
        @(posedge i_clk);
        while (!pose_ch.ready) @(posedge i_clk);
        build_transform(p, m);
        queue_matrix(m);
        @(negedge i_clk);
    endtask

    function automatic logic [31:0] wide_value();
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0001_0000;
            3: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic t_pose_item random_pose();
        t_pose_item p;
        p.roll_angle = 16'($urandom);
        p.pitch_angle = 16'($urandom);
        p.yaw_angle = 16'($urandom);
        p.shift_x = $urandom;
        p.shift_y = $urandom;
        p.shift_z = $urandom;
        p.gain_x = wide_value();
        p.gain_y = wide_value();
        p.gain_z = wide_value();
        return p;
    endfunction

    // Receiver: random stalls, plus one long hold-off when requested.
    initial begin
        int stall;
        mat_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_long) begin
                mat_ch.ready <= 1'b0;
                repeat (120) @(negedge i_clk);
                hold_long = 1'b0;
            end else begin
                stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
                if (stall != 0) begin
                    mat_ch.ready <= 1'b0;
                    repeat (stall) @(negedge i_clk);
                end
            end
            mat_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!mat_ch.valid) @(posedge i_clk);
        end
    end

    // Compare each accepted matrix with the oldest expectation.
    always @(posedge i_clk) begin
        t_mat_item want;
        if (i_rst_n && mat_ch.valid && mat_ch.ready) begin
            if (matrix_queue.size() == 0) begin
                $display("%0t: unexpected matrix %h", $time, mat_ch.data);
                failed = 1'b1;
            end else begin
                want = matrix_queue.pop_front();
                for (int k = 0; k < 12; k++) begin
                    if (want[k*32 +: 32] !== mat_ch.data[k*32 +: 32]) begin
                        $display("%0t: entry %0d expected %h actual %h", $time, 11 - k,
                                 want[k*32 +: 32], mat_ch.data[k*32 +: 32]);
                        failed = 1'b1;
                    end
                end
            end
        end
    end

    // Directed: angle extremes and each quadrant, gain and shift extremes.
    task automatic test_directed();
        t_pose_item p;
        logic [15:0] angs[8];
        angs = '{16'h0000, 16'hFFFF, 16'h4000, 16'h8000,
                 16'hC000, 16'h2000, 16'h3FFF, 16'h7FFF};
        for (int i = 0; i < 8; i++) begin
            p = '0;
            p.roll_angle = angs[i];
            p.pitch_angle = angs[(i + 3) % 8];
            p.yaw_angle = angs[(i + 5) % 8];
            p.gain_x = 32'h0001_0000;
            p.gain_y = 32'h0001_0000;
            p.gain_z = 32'h0001_0000;
            p.shift_x = (i % 2) ? 32'h7FFF_FFFF : 32'h8000_0000;
            p.shift_y = (i % 2) ? 32'h8000_0000 : 32'hFFFF_FFFF;
            p.shift_z = i;
            send_pose(p);
        end
        for (int i = 0; i < 8; i++) begin
            p = random_pose();
            p.gain_x = (i % 2) ? 32'h7FFF_FFFF : 32'h8000_0000;
            p.gain_y = (i % 2) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            p.gain_z = (i < 4) ? 32'h0000_0000 : 32'hFFFF_FFFF;
            send_pose(p);
        end
    endtask

    // Back pressure: a long receiver hold-off while poses keep coming.
    task automatic test_backpressure();
        t_mat_item m;
        hold_long = 1'b1;
        for (int i = 0; i < 60; i++) begin
            pose_ch.data <= random_pose();
            pose_ch.valid <= 1'b1;
            @(posedge i_clk);
            while (!pose_ch.ready) @(posedge i_clk);
            build_transform(pose_ch.data, m);
            queue_matrix(m);
            @(negedge i_clk);
        end
    endtask

    task automatic test_random();
        for (int i = 0; i < 830; i++) begin
            send_pose(random_pose());
        end
    endtask

    initial begin
        int waited;
        i_rst_n = 1'b0;
        pose_ch.valid = 1'b0;
        pose_ch.data = '0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_backpressure();
        test_random();
        pose_ch.valid <= 1'b0;
        waited = 0;
        while (matrix_queue.size() != 0 && waited < 20000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (40) @(posedge i_clk);
        if (!failed && matrix_queue.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #2ms;
        $display("CHECK FAILED");
        $finish;
    end
endmodule

@@ sim.f @@
rtl/core/ptm_pkg.sv
rtl/core/ptm_stream_if.sv
rtl/core/ptm_cordic_cell.sv
rtl/core/ptm_rot_mul.sv
rtl/core/pose_to_scaled_transform_matrix.sv
tb/tb_top.sv
